// ===== design/xsf_pkg.sv =====
// shared types and constants of the xor sprite framebuffer
package xsf_pkg;

  localparam int unsigned LINE_PIXELS = 8;
  localparam int unsigned ROW_PIXELS_W = 64;
  localparam int unsigned IN_DATA_W = 40;
  localparam int unsigned IN_USER_W = 3;
  localparam int unsigned OUT_DATA_W = 72;

  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_DRAW  = 2'd1,
    OP_READ  = 2'd2
  } op_t;

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_t;

endpackage

// ===== design/xor_sprite_framebuffer.sv =====
// top level of the one-bit xor sprite framebuffer
//
// Every item (clear, draw one sprite line, read one row) is taken in ST_IDLE and
// executed in ST_EXEC: in the accept cycle the target row address goes to the row
// memory; in ST_EXEC the registered row comes back, is xored with the sprite mask and
// written to the same row, and the result beat is loaded into the output register.
// ST_EXEC waits while an earlier result in the output register is not taken. A clear
// writes no row: every row carries a flag that reset and clear drop and a write sets;
// a row whose flag is low reads as all pixels off. No clearing pass follows reset. A
// new item is taken while the previous result still waits in the output register.
module xor_sprite_framebuffer #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned HEIGHT = 32,
  parameter int unsigned MAX_LINES = 16
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // start_row, start_col, line_index, sprite_byte, read_row_index
  input  logic [xsf_pkg::IN_DATA_W-1:0]    in_tdata,
  // operation, first_line
  input  logic [xsf_pkg::IN_USER_W-1:0]    in_tuser,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // collision, row_pixels
  output logic [xsf_pkg::OUT_DATA_W-1:0]   out_tdata
);

  localparam int unsigned AW = $clog2(HEIGHT);
  localparam int unsigned CW = $clog2(WIDTH);

  // input beat fields
  logic [1:0] in_op;
  logic       in_first;
  logic [7:0] in_start_row;
  logic [7:0] in_start_col;
  logic [3:0] in_line_index;
  logic [7:0] in_sprite;
  logic [4:0] in_read_row;

  assign in_op         = in_tuser[1:0];
  assign in_first      = in_tuser[2];
  assign in_start_row  = in_tdata[7:0];
  assign in_start_col  = in_tdata[15:8];
  assign in_line_index = in_tdata[19:16];
  assign in_sprite     = in_tdata[27:20];
  assign in_read_row   = in_tdata[32:28];

  xsf_pkg::state_t state_r, state_nxt;

  logic              in_fire;
  logic              exec_fire;
  logic [1:0]        op_r;
  logic              first_r;
  logic              hit_r, hit_nxt;
  logic [AW-1:0]     addr_r, addr_nxt;
  logic [WIDTH-1:0]  mask_r, mask_nxt;
  logic [HEIGHT-1:0] valid_r, valid_nxt;
  logic              coll_r, coll_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [xsf_pkg::OUT_DATA_W-1:0] out_data_r, out_data_nxt;

  logic [WIDTH-1:0]  rd_data;
  logic [WIDTH-1:0]  word;
  logic [WIDTH-1:0]  new_word;
  logic              mem_wr;

  logic [7:0] row_w;
  logic [7:0] col_w;
  logic [8:0] row_sum;
  logic [8:0] col_sum;

  // address and sprite mask, built in the accept cycle
  always_comb begin
    row_w    = in_start_row & 8'(HEIGHT - 1);
    col_w    = in_start_col & 8'(WIDTH - 1);
    row_sum  = {1'b0, row_w} + {5'd0, in_line_index};
    hit_nxt  = 1'b0;
    addr_nxt = AW'(in_read_row);
    mask_nxt = '0;
    col_sum  = '0;
    case (xsf_pkg::op_t'(in_op))
      xsf_pkg::OP_DRAW: begin
        addr_nxt = AW'(row_sum);
        hit_nxt  = ({5'd0, in_line_index} < 9'(MAX_LINES)) && (row_sum < 9'(HEIGHT));
        for (int j = 0; j < xsf_pkg::LINE_PIXELS; j++) begin
          col_sum = {1'b0, col_w} + 9'(j);
          if ((col_sum < 9'(WIDTH)) && in_sprite[xsf_pkg::LINE_PIXELS - 1 - j]) begin
            mask_nxt[col_sum[CW-1:0]] = 1'b1;
          end
        end
      end
      xsf_pkg::OP_READ: begin
        hit_nxt = {4'd0, in_read_row} < 9'(HEIGHT);
      end
      default: begin
        hit_nxt = 1'b0;
      end
    endcase
  end

  xsf_ram #(
    .DW    (WIDTH),
    .DEPTH (HEIGHT),
    .AW    (AW)
  ) u_rows (
    .clk     (clk),
    .wr_en   (mem_wr),
    .wr_addr (addr_r),
    .wr_data (new_word),
    .rd_en   (in_fire),
    .rd_addr (addr_nxt),
    .rd_data (rd_data)
  );

  assign word     = valid_r[addr_r] ? rd_data : '0;
  assign new_word = word ^ mask_r;

  // control and result
  always_comb begin
    state_nxt     = state_r;
    in_tready     = 1'b0;
    exec_fire     = 1'b0;
    mem_wr        = 1'b0;
    valid_nxt     = valid_r;
    coll_nxt      = coll_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      xsf_pkg::ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          state_nxt = xsf_pkg::ST_EXEC;
        end
      end
      xsf_pkg::ST_EXEC: begin
        if (!out_valid_r || out_tready) begin
          exec_fire     = 1'b1;
          state_nxt     = xsf_pkg::ST_IDLE;
          out_valid_nxt = 1'b1;
          out_data_nxt  = '0;
          case (xsf_pkg::op_t'(op_r))
            xsf_pkg::OP_CLEAR: begin
              valid_nxt = '0;
            end
            xsf_pkg::OP_DRAW: begin
              if (first_r) begin
                coll_nxt = 1'b0;
              end
              if (hit_r) begin
                mem_wr            = 1'b1;
                valid_nxt[addr_r] = 1'b1;
                if (|(word & mask_r)) begin
                  coll_nxt = 1'b1;
                end
              end
              out_data_nxt[0] = coll_nxt;
            end
            xsf_pkg::OP_READ: begin
              if (hit_r) begin
                out_data_nxt[xsf_pkg::ROW_PIXELS_W:1] = xsf_pkg::ROW_PIXELS_W'(word);
              end
            end
            default: begin
              out_data_nxt = '0;
            end
          endcase
        end
      end
      default: begin
        state_nxt = xsf_pkg::ST_IDLE;
      end
    endcase
  end

  assign in_fire = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= xsf_pkg::ST_IDLE;
      valid_r     <= '0;
      coll_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      valid_r     <= valid_nxt;
      coll_r      <= coll_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    if (in_fire) begin
      op_r    <= in_op;
      first_r <= in_first;
      hit_r   <= hit_nxt;
      addr_r  <= addr_nxt;
      mask_r  <= mask_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  a_accept_exec : assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> state_r == xsf_pkg::ST_EXEC)
    else $error("accepted beat did not enter execute");

  a_exec_result : assert property (@(posedge clk) disable iff (!rst_n)
    exec_fire |=> out_valid_r)
    else $error("executed item produced no result beat");

  a_clear_rows : assert property (@(posedge clk) disable iff (!rst_n)
    (exec_fire && op_r == xsf_pkg::OP_CLEAR) |=> valid_r == '0)
    else $error("clear left rows marked written");

  a_no_accept_exec : assert property (@(posedge clk) disable iff (!rst_n)
    state_r == xsf_pkg::ST_EXEC |-> !in_tready)
    else $error("beat taken while an item is in execute");

endmodule

// ===== design/xsf_ram.sv =====
// generic single-port-write, registered-read memory
module xsf_ram #(
  parameter int unsigned DW = 64,
  parameter int unsigned DEPTH = 32,
  parameter int unsigned AW = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [DW-1:0] wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [DW-1:0] rd_data
);

  logic [DW-1:0] mem_r [DEPTH];
  logic [DW-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== tb/xsf_checker.sv =====
// beat monitor, framebuffer predictor and result comparison for the xor sprite framebuffer
`timescale 1ns / 100ps

module xsf_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  input  logic                           in_tready,
  // start_row, start_col, line_index, sprite_byte, read_row_index
  input  logic [xsf_pkg::IN_DATA_W-1:0]  in_tdata,
  // operation, first_line
  input  logic [xsf_pkg::IN_USER_W-1:0]  in_tuser,
  input  logic                           out_tvalid,
  input  logic                           out_tready,
  // collision, row_pixels
  input  logic [xsf_pkg::OUT_DATA_W-1:0] out_tdata,
  output int                             mismatches,
  output int                             pending
);

  localparam int ROWS = 32;
  localparam int COLS = 64;
  localparam int LINES = 16;

  typedef struct packed {
    logic        collision;
    logic [63:0] row_pixels;
  } result_t;

  logic [63:0] frame [ROWS];
  logic        hit_seen;
  result_t     due_results[$];

  task automatic xor_sprite_line(input logic [7:0] srow, input logic [7:0] scol,
                                 input logic [3:0] idx, input logic [7:0] bits,
                                 input logic first);
    int r;
    int c;
    logic [4:0] ri;
    logic [5:0] ci;
    if (first) hit_seen = 1'b0;
    r = (int'(srow) % ROWS) + int'(idx);
    if (int'(idx) < LINES && r < ROWS) begin
      ri = 5'(r);
      for (int j = 0; j < 8; j++) begin
        c = (int'(scol) % COLS) + j;
        if (c >= COLS) break;
        ci = 6'(c);
        if (bits[7-j]) begin
          if (frame[ri][ci]) hit_seen = 1'b1;
          frame[ri][ci] = ~frame[ri][ci];
        end
      end
    end
  endtask

  always @(posedge clk) begin : watch
    result_t want;
    result_t got;
    if (!rst_n) begin
      for (int i = 0; i < ROWS; i++) frame[i] = '0;
      hit_seen = 1'b0;
      mismatches = 0;
      due_results.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        got.collision = out_tdata[0];
        got.row_pixels = out_tdata[64:1];
        if (due_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: result beat with nothing expected, collision %0b pixels %h",
                     $realtime, got.collision, got.row_pixels);
        end else begin
          want = due_results.pop_front();
          if (want.collision !== got.collision) begin
            mismatches++;
            if (mismatches <= 10)
              $display("%0t: collision expected %0b got %0b",
                       $realtime, want.collision, got.collision);
          end
          if (want.row_pixels !== got.row_pixels) begin
            mismatches++;
            if (mismatches <= 10)
              $display("%0t: row_pixels expected %h got %h",
                       $realtime, want.row_pixels, got.row_pixels);
          end
        end
      end
      if (in_tvalid && in_tready) begin
        want = '0;
        case (in_tuser[1:0])
          xsf_pkg::OP_CLEAR: for (int i = 0; i < ROWS; i++) frame[i] = '0;
          xsf_pkg::OP_DRAW: begin
            xor_sprite_line(in_tdata[7:0], in_tdata[15:8], in_tdata[19:16],
                            in_tdata[27:20], in_tuser[2]);
            want.collision = hit_seen;
          end
          xsf_pkg::OP_READ: want.row_pixels = frame[in_tdata[32:28]];
          default: ;
        endcase
        due_results.push_back(want);
      end
    end
    pending = due_results.size();
  end

endmodule

// ===== tb/tb_xor_sprite_framebuffer.sv =====
// stimulus and verdict for the xor sprite framebuffer
`timescale 1ns / 100ps

module tb_xor_sprite_framebuffer;

  localparam logic [1:0] OP_UNKNOWN = 2'd3;
  localparam int STALL_LIMIT = 2000;
  localparam int PHASE_ITEMS = 315;

  logic                           clk = 1'b0;
  logic                           rst_n = 1'b0;
  logic                           in_tvalid = 1'b0;
  logic                           in_tready;
  logic [xsf_pkg::IN_DATA_W-1:0]  in_tdata = '0;
  logic [xsf_pkg::IN_USER_W-1:0]  in_tuser = '0;
  logic                           out_tvalid;
  logic                           out_tready = 1'b0;
  logic [xsf_pkg::OUT_DATA_W-1:0] out_tdata;

  int mismatches;
  int pending;
  int idle_pct = 0;
  int stall_pct = 0;
  int quiet_cycles = 0;
  int items_sent = 0;

  xor_sprite_framebuffer uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata(in_tdata),
    .in_tuser(in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata(out_tdata)
  );

  xsf_checker chk (
    .clk(clk),
    .rst_n(rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata(in_tdata),
    .in_tuser(in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata(out_tdata),
    .mismatches(mismatches),
    .pending(pending)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    out_tready <= ($urandom_range(0, 99) >= stall_pct);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic send(input logic [1:0] op, input logic [7:0] srow, input logic [7:0] scol,
                      input logic [3:0] idx, input logic [7:0] bits, input logic first,
                      input logic [4:0] rrow);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {7'b0, rrow, bits, idx, scol, srow};
    in_tuser <= {first, op};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    items_sent++;
  endtask

  task automatic send_random(input logic [1:0] op);
    send(op, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
         4'($urandom_range(0, 15)), 8'($urandom_range(0, 255)),
         1'($urandom_range(0, 1)), 5'($urandom_range(0, 31)));
  endtask

  task automatic send_sprite();
    int lines;
    logic [7:0] srow;
    logic [7:0] scol;
    lines = ($urandom_range(0, 9) == 0) ? int'($urandom_range(1, 16))
                                        : int'($urandom_range(1, 5));
    srow = 8'($urandom_range(0, 255));
    scol = 8'($urandom_range(0, 255));
    for (int l = 0; l < lines; l++)
      send(xsf_pkg::OP_DRAW, srow, scol, 4'(l), 8'($urandom_range(0, 255)), l == 0,
           5'($urandom_range(0, 31)));
  endtask

  task automatic random_phase(input int target);
    int pick;
    target = items_sent + target;
    while (items_sent < target) begin
      pick = $urandom_range(0, 99);
      if (pick < 55)
        send_sprite();
      else if (pick < 85)
        send_random(xsf_pkg::OP_READ);
      else if (pick < 87)
        send_random(xsf_pkg::OP_CLEAR);
      else if (pick < 97)
        send_random(xsf_pkg::OP_DRAW);
      else
        send_random(OP_UNKNOWN);
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed part, no idling
    send(xsf_pkg::OP_CLEAR, 8'd0, 8'd0, 4'd0, 8'h00, 1'b0, 5'd0);
    send(xsf_pkg::OP_READ, 8'd0, 8'd0, 4'd0, 8'h00, 1'b0, 5'd0);
    send(xsf_pkg::OP_DRAW, 8'd0, 8'd0, 4'd0, 8'hff, 1'b1, 5'd0);
    send(xsf_pkg::OP_READ, 8'd0, 8'd0, 4'd0, 8'h00, 1'b0, 5'd0);
    send(xsf_pkg::OP_DRAW, 8'd0, 8'd0, 4'd0, 8'hff, 1'b1, 5'd0);
    send(xsf_pkg::OP_DRAW, 8'd0, 8'd0, 4'd1, 8'h80, 1'b0, 5'd0);
    send(xsf_pkg::OP_DRAW, 8'd255, 8'd60, 4'd0, 8'hff, 1'b1, 5'd31);
    send(xsf_pkg::OP_READ, 8'd0, 8'd0, 4'd0, 8'h00, 1'b0, 5'd31);
    send(xsf_pkg::OP_DRAW, 8'd255, 8'd255, 4'd0, 8'h80, 1'b0, 5'd0);
    send(xsf_pkg::OP_READ, 8'd0, 8'd0, 4'd0, 8'h00, 1'b0, 5'd31);
    // below bottom edge, accumulator still reported
    send(xsf_pkg::OP_DRAW, 8'd30, 8'd0, 4'd2, 8'hff, 1'b0, 5'd0);
    send(xsf_pkg::OP_DRAW, 8'd30, 8'd0, 4'd2, 8'hff, 1'b1, 5'd0);
    send(xsf_pkg::OP_DRAW, 8'd0, 8'd3, 4'd15, 8'h01, 1'b1, 5'd0);
    send(xsf_pkg::OP_READ, 8'd0, 8'd0, 4'd0, 8'h00, 1'b0, 5'd15);
    send(xsf_pkg::OP_DRAW, 8'd16, 8'd57, 4'd15, 8'h00, 1'b1, 5'd0);
    send(xsf_pkg::OP_DRAW, 8'd33, 8'd65, 4'd0, 8'h81, 1'b0, 5'd1);
    send(xsf_pkg::OP_READ, 8'd0, 8'd0, 4'd0, 8'h00, 1'b0, 5'd1);
    send(OP_UNKNOWN, 8'hff, 8'hff, 4'hf, 8'hff, 1'b1, 5'h1f);
    send(xsf_pkg::OP_READ, 8'hff, 8'hff, 4'hf, 8'hff, 1'b1, 5'h1f);
    send(xsf_pkg::OP_DRAW, 8'hff, 8'hff, 4'hf, 8'hff, 1'b1, 5'h1f);
    // clear keeps the collision accumulator
    send(xsf_pkg::OP_DRAW, 8'd1, 8'd0, 4'd0, 8'h81, 1'b1, 5'd0);
    send(xsf_pkg::OP_CLEAR, 8'hff, 8'hff, 4'hf, 8'hff, 1'b1, 5'h1f);
    send(xsf_pkg::OP_DRAW, 8'd2, 8'd0, 4'd0, 8'h00, 1'b0, 5'd0);
    send(xsf_pkg::OP_READ, 8'd0, 8'd0, 4'd0, 8'h00, 1'b0, 5'd1);

    idle_pct = 0;
    stall_pct <= 0;
    random_phase(PHASE_ITEMS);
    idle_pct = 78;
    stall_pct <= 0;
    random_phase(PHASE_ITEMS);
    idle_pct = 0;
    stall_pct <= 78;
    random_phase(PHASE_ITEMS);
    idle_pct = 12;
    stall_pct <= 12;
    random_phase(PHASE_ITEMS);
    in_tvalid <= 1'b0;
    @(posedge clk);

    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatches == 0 && pending == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule

// ===== filelist.f =====
design/xsf_pkg.sv
design/xsf_ram.sv
design/xor_sprite_framebuffer.sv
tb/xsf_checker.sv
tb/tb_xor_sprite_framebuffer.sv
